[rtl/ldr_pkg.sv]
// ldr_pkg: widths and constants for the longest distinct run block
// no dependencies; used by rtl/longest_distinct_run.sv
package ldr_pkg;

    localparam int VALUE_WIDTH = 12;
    localparam int IN_VALUE_W  = 12;
    localparam int TABLE_DEPTH = 1 << VALUE_WIDTH;
    localparam int POS_W       = 48;
    localparam int LEN_W       = 32;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef logic [VALUE_WIDTH-1:0] t_addr;
    typedef logic [POS_W-1:0]       t_pos;
    typedef logic [LEN_W-1:0]       t_len;

endpackage

[rtl/longest_distinct_run.sv]
// longest_distinct_run: longest run of distinct values over a flagged sequence
// depends on ldr_pkg; last-seen-position table held in one internal memory
// throughput: one value per cycle; the input stalls during the clearing pass and while a final value waits on i_ready
// result: o_valid is registered; it rises once a final value moves from stage 1 into the result register
// reset: synchronous active low; a clearing pass then zeroes all TABLE_DEPTH (4096) table entries,
// during which o_ready stays low
module longest_distinct_run (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ldr_pkg::IN_VALUE_W-1:0]  i_value,
    input  logic                            i_is_last,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ldr_pkg::LEN_W-1:0]       o_longest_length
);

    // table memory
    ldr_pkg::t_pos  r_last_seen [ldr_pkg::TABLE_DEPTH];
    ldr_pkg::t_pos  r_rd_data;

    // clearing pass
    logic           r_clr_busy;
    ldr_pkg::t_addr r_clr_addr;

    // stage 1
    logic           r_s1_valid;
    ldr_pkg::t_addr r_s1_addr;
    logic           r_s1_last;

    // forwarding of the write that coincided with the last read
    logic           r_fwd_valid;
    ldr_pkg::t_addr r_fwd_addr;
    ldr_pkg::t_pos  r_fwd_tag;

    // sequence state
    ldr_pkg::t_pos  r_pos;
    ldr_pkg::t_pos  r_ws;
    ldr_pkg::t_len  r_best;
    logic           r_open;

    // result register
    logic           r_out_valid;
    ldr_pkg::t_len  r_out_len;

    logic           in_fire;
    logic           s1_fire;
    ldr_pkg::t_addr in_addr;
    ldr_pkg::t_pos  seen;
    ldr_pkg::t_pos  tag;
    ldr_pkg::t_pos  ws_base;
    ldr_pkg::t_pos  n_ws;
    ldr_pkg::t_pos  len_full;
    ldr_pkg::t_len  len_sat;
    ldr_pkg::t_len  best_base;
    ldr_pkg::t_len  n_best;
    logic           mem_we;
    ldr_pkg::t_addr mem_waddr;
    ldr_pkg::t_pos  mem_wdata;

    assign in_addr = i_value[ldr_pkg::VALUE_WIDTH-1:0];

    // a final value may only leave stage 1 when the result slot frees up
    assign s1_fire = r_s1_valid && !(r_s1_last && r_out_valid && !i_ready);
    assign o_ready = !r_clr_busy && (!r_s1_valid || s1_fire);
    assign in_fire = i_valid && o_ready;

    always_comb begin
        tag     = r_pos + ldr_pkg::t_pos'(1);
        seen    = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_tag : r_rd_data;
        ws_base = r_open ? r_ws : r_pos;
        n_ws    = ((seen != '0) && (seen > ws_base)) ? seen : ws_base;
        len_full = tag - n_ws;
        if (len_full[ldr_pkg::POS_W-1:ldr_pkg::LEN_W] != '0) begin
            len_sat = ldr_pkg::LEN_MAX;
        end else begin
            len_sat = len_full[ldr_pkg::LEN_W-1:0];
        end
        best_base = r_open ? r_best : '0;
        n_best    = (len_sat > best_base) ? len_sat : best_base;
    end

    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_fire;
            mem_waddr = r_s1_addr;
            mem_wdata = tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_last_seen[mem_waddr] <= mem_wdata;
        end
        if (in_fire) begin
            r_rd_data <= r_last_seen[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_pos       <= '0;
            r_ws        <= '0;
            r_best      <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ldr_pkg::t_addr'(1);
                if (r_clr_addr == {ldr_pkg::VALUE_WIDTH{1'b1}}) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (in_fire) begin
                r_s1_valid  <= 1'b1;
                // the read just issued misses a write landing on this same edge
                r_fwd_valid <= s1_fire;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_pos  <= tag;
                r_ws   <= n_ws;
                r_best <= n_best;
                r_open <= !r_s1_last;
            end

            if (s1_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_addr  <= in_addr;
            r_s1_last  <= i_is_last;
            r_fwd_addr <= r_s1_addr;
            r_fwd_tag  <= tag;
        end
        if (s1_fire && r_s1_last) begin
            r_out_len <= n_best;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_longest_length = r_out_len;

`ifndef NO_ASSERTIONS
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_ready)
        else $error("request accepted during table clearing");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_last) |-> (!r_out_valid || i_ready))
        else $error("pending result overwritten");

    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted request lost before stage 1");

    a_best_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_open) |=> (r_best >= $past(r_best)))
        else $error("best length decreased inside a sequence");
`endif

endmodule
